// ===== sv/necir_pkg.sv =====
`default_nettype none
package necir_pkg;

	localparam int DurW = 16;
	localparam int RegW = 12;
	localparam int CfgIdxW = 2;
	localparam int FrameBits = 32;
	localparam int BitIdxW = $clog2(FrameBits);

	localparam logic [CfgIdxW-1:0] CFG_UNIT_US = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_MARGIN_US = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_CHECK_ADDRESS = 2'd2;

	localparam logic [1:0] ST_FRAME = 2'd0;
	localparam logic [1:0] ST_REPEAT = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HDR_HIGH,
		PH_BIT_LOW,
		PH_BIT_HIGH
	} phase_t;

	typedef struct packed {
		logic req_type;
		logic level;
		logic [DurW-1:0] duration_us;
	} nir_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] address;
		logic [7:0] command;
	} nir_out_t;

	// duration matches for each unit multiple the protocol uses
	typedef struct packed {
		logic m16;
		logic m8;
		logic m4;
		logic m3;
		logic m1;
	} nir_match_t;

endpackage
`default_nettype wire

// ===== sv/necir_match.sv =====
`default_nettype none
module necir_match
	import necir_pkg::*;
(
	input wire logic [DurW-1:0] duration_us,
	input wire logic [RegW-1:0] unit_us,
	input wire logic [RegW-1:0] margin_us,
	output nir_match_t match
);

	logic [DurW:0] d_plus_m;
	logic [DurW:0] e16;
	logic [DurW:0] e8;
	logic [DurW:0] e4;
	logic [DurW:0] e3;
	logic [DurW:0] e1;

	function automatic logic near(input logic [DurW:0] dpm, input logic [DurW:0] dur,
			input logic [DurW:0] expect_us, input logic [DurW:0] marg);
		// expect - m < d < expect + m, kept unsigned by moving m across
		near = (dpm > expect_us) && (dur < expect_us + marg);
	endfunction

	always_comb begin
		e1 = {{(DurW+1-RegW){1'b0}}, unit_us};
		e3 = (e1 << 1) + e1;
		e4 = e1 << 2;
		e8 = e1 << 3;
		e16 = e1 << 4;
		d_plus_m = {1'b0, duration_us} + {{(DurW+1-RegW){1'b0}}, margin_us};
		match.m16 = near(d_plus_m, {1'b0, duration_us}, e16,
			{{(DurW+1-RegW){1'b0}}, margin_us});
		match.m8 = near(d_plus_m, {1'b0, duration_us}, e8,
			{{(DurW+1-RegW){1'b0}}, margin_us});
		match.m4 = near(d_plus_m, {1'b0, duration_us}, e4,
			{{(DurW+1-RegW){1'b0}}, margin_us});
		match.m3 = near(d_plus_m, {1'b0, duration_us}, e3,
			{{(DurW+1-RegW){1'b0}}, margin_us});
		match.m1 = near(d_plus_m, {1'b0, duration_us}, e1,
			{{(DurW+1-RegW){1'b0}}, margin_us});
	end

endmodule
`default_nettype wire

// ===== sv/necir_fsm.sv =====
`default_nettype none
module necir_fsm
	import necir_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire nir_in_t item,
	input wire nir_match_t match,
	input wire logic check_address,
	output logic res_valid,
	output nir_out_t res
);

	phase_t phase_q, phase_d;
	logic [BitIdxW-1:0] bit_idx_q, bit_idx_d;
	logic [FrameBits-1:0] frame_q, frame_d;
	logic [FrameBits-1:0] frame_new;
	logic is_one;
	logic is_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_idx_q <= '0;
			frame_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			bit_idx_q <= bit_idx_d;
			frame_q <= frame_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		bit_idx_d = bit_idx_q;
		frame_d = frame_q;
		res_valid = 1'b0;
		res = '{status: ST_ERROR, address: 8'd0, command: 8'd0};
		is_one = item.level && match.m3;
		is_zero = item.level && match.m1;
		frame_new = frame_q | ({{(FrameBits-1){1'b0}}, is_one} << bit_idx_q);
		case (phase_q)
			PH_IDLE: begin
				if (!item.req_type) begin
					if (!item.level && match.m16) begin
						phase_d = PH_HDR_HIGH;
					end else begin
						res_valid = 1'b1;
					end
				end
			end
			PH_HDR_HIGH: begin
				phase_d = PH_IDLE;
				bit_idx_d = '0;
				frame_d = '0;
				if (!item.req_type) begin
					if (item.level && match.m8) begin
						phase_d = PH_BIT_LOW;
					end else begin
						res_valid = 1'b1;
						if (item.level && match.m4) begin
							res.status = ST_REPEAT;
						end
					end
				end
			end
			PH_BIT_LOW: begin
				if (item.req_type || item.level || !match.m1) begin
					res_valid = 1'b1;
				end else begin
					phase_d = PH_BIT_HIGH;
				end
			end
			default: begin
				if (item.req_type || !(is_one || is_zero)) begin
					res_valid = 1'b1;
				end else if (bit_idx_q != BitIdxW'(FrameBits - 1)) begin
					phase_d = PH_BIT_LOW;
					bit_idx_d = bit_idx_q + 1'b1;
					frame_d = frame_new;
				end else begin
					res_valid = 1'b1;
					// command must equal its inverted copy; address only if enabled
					if ((frame_new[23:16] == ~frame_new[31:24]) &&
							(!check_address || (frame_new[7:0] == ~frame_new[15:8]))) begin
						res.status = ST_FRAME;
						res.address = frame_new[7:0];
						res.command = frame_new[23:16];
					end
				end
			end
		endcase
		if (res_valid) begin
			phase_d = PH_IDLE;
			bit_idx_d = '0;
			frame_d = '0;
		end
	end

endmodule
`default_nettype wire

// ===== sv/nec_ir_frame_decoder_unit.sv =====
// NEC infrared frame decoder.
// Each accepted input beat is held in the input register; any result it closes is then registered on out_data.
// Throughput: one input beat per cycle; classify and decode sit between the input
// register and the result register, so only a stalled result holds the input side.
// Reset: arst_n clears the decoder to idle, drops both valid flags and restores
// unit_us 563, margin_us 583, check_address 0.
`default_nettype none
module nec_ir_frame_decoder_unit
	import necir_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CfgIdxW-1:0] cfg_index,
	input wire logic [RegW-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire nir_in_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output nir_out_t out_data
);

	logic [RegW-1:0] unit_q;
	logic [RegW-1:0] margin_q;
	logic chk_addr_q;
	logic valid_s1;
	nir_in_t item_s1;
	logic out_valid_q;
	nir_out_t out_data_q;
	logic advance;
	logic accept;
	nir_match_t match;
	logic res_valid;
	nir_out_t res;

	assign advance = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= RegW'(563);
			margin_q <= RegW'(583);
			chk_addr_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UNIT_US: unit_q <= cfg_data;
				CFG_MARGIN_US: margin_q <= cfg_data;
				CFG_CHECK_ADDRESS: chk_addr_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	necir_match u_match (
		.duration_us(item_s1.duration_us),
		.unit_us(unit_q),
		.margin_us(margin_q),
		.match(match)
	);

	necir_fsm u_fsm (
		.clk(clk),
		.arst_n(arst_n),
		.step(valid_s1 && advance),
		.item(item_s1),
		.match(match),
		.check_address(chk_addr_q),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_data_q <= res;
		end
	end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import necir_pkg::*;

	localparam int LIMIT = 200000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [RegW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	nir_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	nir_out_t out_data;

	nec_ir_frame_decoder_unit DUT (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_stall,
		.in_data,
		.out_valid,
		.out_stall,
		.out_data
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder shadow: configuration and frame state
	int unit_cfg = 563;
	int margin_cfg = 583;
	bit addr_chk_cfg = 1'b0;
	phase_t dec_phase = PH_IDLE;
	logic [5:0] dec_idx = '0;
	logic [31:0] dec_bits = '0;

	nir_in_t pulse_q[$];
	nir_out_t decode_q[$];
	nir_out_t got_res;
	nir_out_t want_res;
	int queued = 0;
	int mismatches = 0;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	logic hold_start = 1'b0;
	int hold_left = 0;
	int cycles = 0;

	function automatic bit in_window(input int dur, input int k);
		int ctr;
		ctr = k * unit_cfg;
		return (dur > ctr - margin_cfg) && (dur < ctr + margin_cfg);
	endfunction

	// returns 1 when the pulse closes a frame, repeat or error
	function automatic bit decode_pulse(input nir_in_t it, output nir_out_t res);
		bit to;
		int d;
		to = it.req_type;
		d = int'(it.duration_us);
		res = '0;
		case (dec_phase)
			PH_IDLE: begin
				if (to)
					return 1'b0;
				if (!it.level && in_window(d, 16)) begin
					dec_phase = PH_HDR_HIGH;
					return 1'b0;
				end
				res.status = ST_ERROR;
			end
			PH_HDR_HIGH: begin
				if (to) begin
					dec_phase = PH_IDLE;
					dec_idx = '0;
					dec_bits = '0;
					return 1'b0;
				end
				if (it.level && in_window(d, 8)) begin
					dec_phase = PH_BIT_LOW;
					dec_idx = '0;
					dec_bits = '0;
					return 1'b0;
				end
				res.status = (it.level && in_window(d, 4)) ? ST_REPEAT : ST_ERROR;
			end
			PH_BIT_LOW: begin
				if (to || it.level || !in_window(d, 1)) begin
					res.status = ST_ERROR;
				end else begin
					dec_phase = PH_BIT_HIGH;
					return 1'b0;
				end
			end
			default: begin
				if (to || !it.level || (!in_window(d, 3) && !in_window(d, 1))) begin
					res.status = ST_ERROR;
				end else begin
					// a one wins where the two windows overlap
					if (in_window(d, 3))
						dec_bits[dec_idx[4:0]] = 1'b1;
					dec_idx = dec_idx + 6'd1;
					if (dec_idx < 6'd32) begin
						dec_phase = PH_BIT_LOW;
						return 1'b0;
					end
					if (dec_bits[23:16] != ~dec_bits[31:24])
						res.status = ST_ERROR;
					else if (addr_chk_cfg && dec_bits[7:0] != ~dec_bits[15:8])
						res.status = ST_ERROR;
					else begin
						res.status = ST_FRAME;
						res.address = dec_bits[7:0];
						res.command = dec_bits[23:16];
					end
				end
			end
		endcase
		dec_phase = PH_IDLE;
		dec_idx = '0;
		dec_bits = '0;
		return 1'b1;
	endfunction

	function automatic nir_in_t mk(input bit to, input bit lvl, input int dur);
		nir_in_t it;
		it.req_type = to;
		it.level = lvl;
		it.duration_us = dur[DurW-1:0];
		return it;
	endfunction

	// pulse of k units inside the current window, random when no window exists
	function automatic nir_in_t pulse(input bit lvl, input int k);
		int lo, hi;
		lo = k * unit_cfg - margin_cfg + 1;
		hi = k * unit_cfg + margin_cfg - 1;
		if (lo < 0)
			lo = 0;
		if (hi > 65535)
			hi = 65535;
		if (lo > hi)
			return mk(1'b0, lvl, $urandom_range(65535));
		return mk(1'b0, lvl, $urandom_range(hi, lo));
	endfunction

	function automatic nir_in_t noise_pulse();
		return mk(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(65535));
	endfunction

	task automatic push(input nir_in_t it);
		pulse_q.push_back(it);
		queued++;
	endtask

	task automatic queue_frame(input logic [7:0] adr, input logic [7:0] cmd, input bit bad_cmd,
			input bit bad_adr, input int cut);
		logic [31:0] word;
		nir_in_t seq[$];
		word[7:0] = adr;
		word[15:8] = ~adr ^ (bad_adr ? 8'($urandom_range(255, 1)) : 8'h00);
		word[23:16] = cmd;
		word[31:24] = ~cmd ^ (bad_cmd ? 8'($urandom_range(255, 1)) : 8'h00);
		seq.push_back(pulse(1'b0, 16));
		seq.push_back(pulse(1'b1, 8));
		for (int i = 0; i < FrameBits; i++) begin
			seq.push_back(pulse(1'b0, 1));
			seq.push_back(pulse(1'b1, word[i] ? 3 : 1));
		end
		if (cut >= 0) begin
			seq[cut] = noise_pulse();
			if ($urandom_range(1))
				seq = seq[0:cut];
		end
		foreach (seq[i])
			push(seq[i]);
	endtask

	task automatic queue_random(input int n);
		int start, r, cut;
		start = queued;
		while (queued - start < n) begin
			r = $urandom_range(99);
			if (r < 55) begin
				cut = ($urandom_range(99) < 15) ? int'($urandom_range(65)) : -1;
				queue_frame(8'($urandom), 8'($urandom), $urandom_range(99) < 15,
					$urandom_range(99) < 40, cut);
			end else if (r < 70) begin
				push(pulse(1'b0, 16));
				push(pulse(1'b1, 4));
			end else if (r < 80) begin
				push(noise_pulse());
			end else if (r < 88) begin
				push(mk(1'b1, 1'($urandom_range(1)), $urandom_range(65535)));
			end else if (r < 94) begin
				push(pulse(1'b0, 16));
				push(mk(1'b1, 1'($urandom_range(1)), $urandom_range(65535)));
			end else begin
				push(pulse(1'b0, 16));
				push(noise_pulse());
			end
		end
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[RegW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_UNIT_US: unit_cfg = val;
			CFG_MARGIN_US: margin_cfg = val;
			CFG_CHECK_ADDRESS: addr_chk_cfg = val[0];
			default: ;
		endcase
	endtask

	task automatic configure(input int u, input int m, input bit chk);
		write_reg(CFG_UNIT_US, u);
		write_reg(CFG_MARGIN_US, m);
		write_reg(CFG_CHECK_ADDRESS, int'(chk));
	endtask

	// wait until every beat is in and every result out, then let the pipe settle
	task automatic drain();
		while (pulse_q.size() != 0 || in_valid || decode_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input int u, input int m, input bit chk, input int snd,
			input int rcv, input int n);
		configure(u, m, chk);
		snd_idle_pct = snd;
		rcv_stall_pct = rcv;
		queue_random(n);
		drain();
	endtask

	// input driver; predicts each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid && decode_pulse(in_data, got_res))
				decode_q.push_back(got_res);
			if (pulse_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pulse_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_start)
			hold_left <= LONG_HOLD;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (decode_q.size() == 0) begin
					$error("unexpected result beat: status %0d address %0h command %0h",
						out_data.status, out_data.address, out_data.command);
					mismatches++;
				end else begin
					want_res = decode_q.pop_front();
					if (out_data.status !== want_res.status) begin
						$error("status: expected %0d, got %0d", want_res.status, out_data.status);
						mismatches++;
					end
					if (out_data.address !== want_res.address) begin
						$error("address: expected %0h, got %0h", want_res.address,
							out_data.address);
						mismatches++;
					end
					if (out_data.command !== want_res.command) begin
						$error("command: expected %0h, got %0h", want_res.command,
							out_data.command);
						mismatches++;
					end
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values, hand-picked pulses around the window edges
		push(mk(1'b1, 1'b0, 0));
		push(mk(1'b1, 1'b1, 65535));
		push(mk(1'b0, 1'b1, 16 * unit_cfg));
		push(mk(1'b0, 1'b0, 0));
		push(mk(1'b0, 1'b0, 65535));
		push(mk(1'b0, 1'b0, 16 * unit_cfg - margin_cfg));
		push(mk(1'b0, 1'b0, 16 * unit_cfg - margin_cfg + 1));
		push(mk(1'b1, 1'b0, 0));
		push(mk(1'b0, 1'b0, 16 * unit_cfg + margin_cfg - 1));
		push(mk(1'b0, 1'b1, 4 * unit_cfg));
		push(mk(1'b0, 1'b0, 16 * unit_cfg));
		push(mk(1'b0, 1'b1, 8 * unit_cfg + margin_cfg));
		push(mk(1'b0, 1'b0, 16 * unit_cfg));
		push(mk(1'b0, 1'b0, 8 * unit_cfg));
		push(mk(1'b0, 1'b0, 16 * unit_cfg));
		push(mk(1'b0, 1'b1, 8 * unit_cfg));
		push(mk(1'b1, 1'b0, 0));
		push(mk(1'b0, 1'b0, 16 * unit_cfg));
		push(mk(1'b0, 1'b1, 8 * unit_cfg));
		push(mk(1'b0, 1'b1, unit_cfg));
		push(mk(1'b0, 1'b0, 16 * unit_cfg));
		push(mk(1'b0, 1'b1, 8 * unit_cfg));
		push(mk(1'b0, 1'b0, unit_cfg));
		push(mk(1'b0, 1'b1, 65535));
		push(mk(1'b0, 1'b0, 16 * unit_cfg));
		push(mk(1'b0, 1'b1, 8 * unit_cfg));
		push(mk(1'b0, 1'b0, unit_cfg));
		push(mk(1'b1, 1'b1, unit_cfg));
		drain();

		run_phase(563, 583, 1'b0, 0, 0, 250);
		run_phase(1, 1, 1'b1, 47, 0, 250);
		run_phase(4095, 4095, 1'b0, 0, 47, 250);
		run_phase(500, 100, 1'b1, 16, 16, 250);
		// nothing can match with a zero margin
		run_phase(1, 0, 1'b0, 0, 47, 60);

		// receiver holds off while beats keep coming, then the sender waits it out
		configure(4095, 1, 1'b1);
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		repeat (30) push(noise_pulse());
		queue_random(200);
		@(posedge clk);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		drain();
		queue_random(150);
		drain();

		run_phase(563, 20, 1'b1, 16, 16, 250);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/necir_pkg.sv
sv/necir_match.sv
sv/necir_fsm.sv
sv/nec_ir_frame_decoder_unit.sv
dv/tb.sv
